// File: rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants and types for the pixel pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// Default number of fraction bits of saturation and brightness.
	localparam int FRAC_BITS_DEF = 12;

	// Register stages from input to output.
	localparam int PIPE_DEPTH = 7;

	// Width of one hue sector in degrees, and the width of a sector weight.
	localparam int SEC_DEG = 60;
	localparam int KW      = 6;

	// Hue is offset by a multiple of 360 so that it is never negative.
	localparam int HUE_BIAS = 33120;
	localparam int HUE_W    = 17;

	// Reciprocal of 360 for the hue remainder: floor(2^HUE_SHIFT / 360).
	localparam int HUE_SHIFT = 24;
	localparam int HUE_RECIP = (1 << HUE_SHIFT) / 360;
	localparam int HUE_QW    = 8;

	// Per-stage load enables, bit 0 is the first stage.
	typedef logic [PIPE_DEPTH-1:0] stage_en_t;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

endpackage

// File: rtl/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Clamps saturation and brightness and wraps the hue into 0..359 over
// three stages: bias, reciprocal multiply, remainder with one correction.
// ----------------------------------------------------------------------------
module hsvrgb_front
	import hsvrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  stage_en_t            stage_en,
	input  logic [15:0]          hue_angle,
	input  logic [15:0]          saturation,
	input  logic [15:0]          brightness,
	output logic [8:0]           hue_s3,
	output logic [FRAC_BITS:0]   sat_s3,
	output logic [FRAC_BITS:0]   bri_s3
);

	localparam int VW = FRAC_BITS + 1;
	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

	function automatic logic [VW-1:0] clamp_unit(input logic [15:0] x);
		logic [VW-1:0] res;
		if (x[15]) begin
			res = '0;
		end else if (32'(x[14:0]) > ONE) begin
			res = ONE[VW-1:0];
		end else begin
			res = VW'(x[14:0]);
		end
		return res;
	endfunction

	logic [HUE_W-1:0]  hue_s1;
	logic [VW-1:0]     sat_s1;
	logic [VW-1:0]     bri_s1;
	logic [HUE_W-1:0]  hue_s2;
	logic [HUE_QW-1:0] quo_s2;
	logic [VW-1:0]     sat_s2;
	logic [VW-1:0]     bri_s2;

	logic [HUE_W+15:0] recip_prod;
	logic [HUE_W-1:0]  rem_raw;
	logic [HUE_W-1:0]  rem_fix;

	// Stage 1: the bias keeps the value congruent modulo 360 and non-negative.
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			hue_s1 <= {hue_angle[15], hue_angle} + HUE_W'(HUE_BIAS);
			sat_s1 <= clamp_unit(saturation);
			bri_s1 <= clamp_unit(brightness);
		end
	end

	// Stage 2: the truncated reciprocal may leave the quotient one too low.
	assign recip_prod = (HUE_W + 16)'(hue_s1) * (HUE_W + 16)'(HUE_RECIP);

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			hue_s2 <= hue_s1;
			quo_s2 <= recip_prod[HUE_SHIFT +: HUE_QW];
			sat_s2 <= sat_s1;
			bri_s2 <= bri_s1;
		end
	end

	// Stage 3: the raw remainder is below 720, so one subtraction corrects it.
	assign rem_raw = hue_s2 - HUE_W'(quo_s2) * HUE_W'(360);
	assign rem_fix = (rem_raw >= HUE_W'(360)) ? rem_raw - HUE_W'(360) : rem_raw;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			hue_s3 <= rem_fix[8:0];
			sat_s3 <= sat_s2;
			bri_s3 <= bri_s2;
		end
	end

endmodule

// File: rtl/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// HSV to RGB sector decode
// Splits the wrapped hue into a sector and an offset, and picks for each
// channel the weight k of its component V * (60 - S * k / ONE).
// ----------------------------------------------------------------------------
module hsvrgb_sector
	import hsvrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  stage_en_t          stage_en,
	input  logic [8:0]         hue_s3,
	input  logic [FRAC_BITS:0] sat_s3,
	input  logic [FRAC_BITS:0] bri_s3,
	output logic [KW-1:0]      k_red_s4,
	output logic [KW-1:0]      k_green_s4,
	output logic [KW-1:0]      k_blue_s4,
	output logic [FRAC_BITS:0] sat_s4,
	output logic [FRAC_BITS:0] bri_s4
);

	sector_t       sector;
	logic [8:0]    base;
	logic [KW-1:0] offs;
	logic [KW-1:0] k_v;
	logic [KW-1:0] k_p;
	logic [KW-1:0] k_q;
	logic [KW-1:0] k_t;
	logic [KW-1:0] k_red;
	logic [KW-1:0] k_green;
	logic [KW-1:0] k_blue;

	always_comb begin
		priority if (hue_s3 >= 9'd300) begin
			sector = SEC_MAGENTA_RED;
			base   = 9'd300;
		end else if (hue_s3 >= 9'd240) begin
			sector = SEC_BLUE_MAGENTA;
			base   = 9'd240;
		end else if (hue_s3 >= 9'd180) begin
			sector = SEC_CYAN_BLUE;
			base   = 9'd180;
		end else if (hue_s3 >= 9'd120) begin
			sector = SEC_GREEN_CYAN;
			base   = 9'd120;
		end else if (hue_s3 >= 9'd60) begin
			sector = SEC_YELLOW_GREEN;
			base   = 9'd60;
		end else begin
			sector = SEC_RED_YELLOW;
			base   = 9'd0;
		end
	end

	assign offs = KW'(hue_s3 - base);

	// Weights: full value, p = V(1-S), q = V(1-S*f), t = V(1-S*(1-f)).
	assign k_v = '0;
	assign k_p = KW'(SEC_DEG);
	assign k_q = offs;
	assign k_t = KW'(SEC_DEG) - offs;

	always_comb begin
		unique case (sector)
			SEC_RED_YELLOW: begin
				k_red = k_v; k_green = k_t; k_blue = k_p;
			end
			SEC_YELLOW_GREEN: begin
				k_red = k_q; k_green = k_v; k_blue = k_p;
			end
			SEC_GREEN_CYAN: begin
				k_red = k_p; k_green = k_v; k_blue = k_t;
			end
			SEC_CYAN_BLUE: begin
				k_red = k_p; k_green = k_q; k_blue = k_v;
			end
			SEC_BLUE_MAGENTA: begin
				k_red = k_t; k_green = k_p; k_blue = k_v;
			end
			SEC_MAGENTA_RED: begin
				k_red = k_v; k_green = k_p; k_blue = k_q;
			end
			default: begin
				k_red = k_v; k_green = k_t; k_blue = k_p;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			k_red_s4   <= k_red;
			k_green_s4 <= k_green;
			k_blue_s4  <= k_blue;
			sat_s4     <= sat_s3;
			bri_s4     <= bri_s3;
		end
	end

endmodule

// File: rtl/hsvrgb_chan.sv
// ----------------------------------------------------------------------------
// HSV to RGB channel
// Computes one 8-bit channel as floor(255 * V * (60*ONE - S*k) / (60*ONE^2)).
// Since 255/60 is 17/4, the scaling is a shift-add and a shift.
// ----------------------------------------------------------------------------
module hsvrgb_chan
	import hsvrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  stage_en_t          stage_en,
	input  logic [KW-1:0]      k_s4,
	input  logic [FRAC_BITS:0] sat_s4,
	input  logic [FRAC_BITS:0] bri_s4,
	output logic [7:0]         chan_s7
);

	localparam int VW = FRAC_BITS + 1;
	localparam int XW = FRAC_BITS + KW;
	localparam int PW = 2 * FRAC_BITS + KW;
	localparam int SW = PW + 5;
	localparam logic [XW-1:0] FULL = XW'(SEC_DEG * (1 << FRAC_BITS));

	logic [XW-1:0] sk;
	logic [XW-1:0] comp_s5;
	logic [VW-1:0] bri_s5;
	logic [PW-1:0] prod_s6;
	logic [SW-1:0] scaled;

	assign sk = XW'(sat_s4) * XW'(k_s4);

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			comp_s5 <= FULL - sk;
			bri_s5  <= bri_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			prod_s6 <= PW'(bri_s5) * PW'(comp_s5);
		end
	end

	// Multiply by 17, then drop the denominator 4 * ONE^2. The result never
	// exceeds 255.
	assign scaled = (SW'(prod_s6) << 4) + SW'(prod_s6);

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			chan_s7 <= scaled[2*FRAC_BITS+2 +: 8];
		end
	end

endmodule

// File: rtl/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter, top level
// Converts one HSV pixel to 8-bit RGB per clock cycle when not stalled.
// ----------------------------------------------------------------------------
// The converter takes one pixel transfer per clock cycle while in_stall is low
// and passes each result through its stages: three stages wrap the hue (bias, a
// multiply by the reciprocal of 360, and a remainder correction), one stage
// decodes the sector, and three stages form each channel (weight multiply,
// brightness multiply, scaling to a byte). The stages hold on their own, so a
// stall at the output fills empty stages first and reaches in_stall only once
// every stage holds a pixel. Results are exact: each channel is the truncated
// value of component times 255.
module hsv_to_rgb_converter_top
	import hsvrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] hue_angle,
	input  logic [15:0] saturation,
	input  logic [15:0] brightness,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	logic [PIPE_DEPTH-1:0] valid_q;
	logic [PIPE_DEPTH:0]   ready;
	stage_en_t             stage_en;

	logic [8:0]         hue_s3;
	logic [FRAC_BITS:0] sat_s3;
	logic [FRAC_BITS:0] bri_s3;
	logic [KW-1:0]      k_red_s4;
	logic [KW-1:0]      k_green_s4;
	logic [KW-1:0]      k_blue_s4;
	logic [FRAC_BITS:0] sat_s4;
	logic [FRAC_BITS:0] bri_s4;

	// A stage can load when it is empty or when the stage after it moves on.
	always_comb begin
		ready[PIPE_DEPTH] = !out_stall;
		for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
			ready[i] = !valid_q[i] || ready[i+1];
		end
	end

	assign stage_en = ready[PIPE_DEPTH-1:0];
	assign in_stall = !ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < PIPE_DEPTH; i++) begin
				if (stage_en[i]) begin
					valid_q[i] <= (i == 0) ? in_valid : valid_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign out_valid = valid_q[PIPE_DEPTH-1];

	hsvrgb_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.stage_en   (stage_en),
		.hue_angle  (hue_angle),
		.saturation (saturation),
		.brightness (brightness),
		.hue_s3     (hue_s3),
		.sat_s3     (sat_s3),
		.bri_s3     (bri_s3)
	);

	hsvrgb_sector #(
		.FRAC_BITS(FRAC_BITS)
	) u_sector (
		.clk        (clk),
		.stage_en   (stage_en),
		.hue_s3     (hue_s3),
		.sat_s3     (sat_s3),
		.bri_s3     (bri_s3),
		.k_red_s4   (k_red_s4),
		.k_green_s4 (k_green_s4),
		.k_blue_s4  (k_blue_s4),
		.sat_s4     (sat_s4),
		.bri_s4     (bri_s4)
	);

	hsvrgb_chan #(
		.FRAC_BITS(FRAC_BITS)
	) u_chan_red (
		.clk      (clk),
		.stage_en (stage_en),
		.k_s4     (k_red_s4),
		.sat_s4   (sat_s4),
		.bri_s4   (bri_s4),
		.chan_s7  (red)
	);

	hsvrgb_chan #(
		.FRAC_BITS(FRAC_BITS)
	) u_chan_green (
		.clk      (clk),
		.stage_en (stage_en),
		.k_s4     (k_green_s4),
		.sat_s4   (sat_s4),
		.bri_s4   (bri_s4),
		.chan_s7  (green)
	);

	hsvrgb_chan #(
		.FRAC_BITS(FRAC_BITS)
	) u_chan_blue (
		.clk      (clk),
		.stage_en (stage_en),
		.k_s4     (k_blue_s4),
		.sat_s4   (sat_s4),
		.bri_s4   (bri_s4),
		.chan_s7  (blue)
	);

endmodule
